// ----- rtl/gtr_pkg.sv -----
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types and constants of the glyph text renderer: input function
// codes, command queue entry, font geometry and configuration bundle.
// ----------------------------------------------------------------------------
package gtr_pkg;

  // input function codes
  localparam logic [1:0] FUNC_CURSOR = 2'd0;
  localparam logic [1:0] FUNC_TEXT   = 2'd1;
  localparam logic [1:0] FUNC_BITMAP = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_FG_COLOR    = 3'd0;
  localparam logic [2:0] REG_BG_COLOR    = 3'd1;
  localparam logic [2:0] REG_FONT_MODE   = 3'd2;
  localparam logic [2:0] REG_ASCII_BASE  = 3'd3;
  localparam logic [2:0] REG_SMALL_BASE  = 3'd4;
  localparam logic [2:0] REG_LARGE_BASE  = 3'd5;

  // result kinds
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_PIX = 1'b1;

  // text decode constants
  localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
  localparam logic [31:0] ASCII_FIRST  = 32'd32;
  localparam logic [15:0] GBK_LEAD_MIN = 16'h0081;
  localparam logic [7:0]  GBK_GAP      = 8'h7F;
  localparam logic [15:0] GBK_LOW_OFS  = 16'h0040;
  localparam logic [15:0] GBK_HIGH_OFS = 16'h0041;
  localparam logic [23:0] GBK_ZONE_SPAN = 24'd190;

  // glyph geometry: advance, wrap limit, line height, window width and height
  localparam logic [15:0] ASCII_STEP  = 16'd8;
  localparam logic [15:0] ASCII_LIMIT_X = 16'd233;
  localparam logic [15:0] ASCII_LINE  = 16'd16;
  localparam logic [15:0] ASCII_W     = 16'd8;
  localparam logic [15:0] ASCII_H     = 16'd16;
  localparam logic [15:0] SMALL_STEP  = 16'd16;
  localparam logic [15:0] SMALL_LIMIT_X = 16'd225;
  localparam logic [15:0] SMALL_LINE  = 16'd16;
  localparam logic [15:0] SMALL_W     = 16'd16;
  localparam logic [15:0] SMALL_H     = 16'd16;
  localparam logic [15:0] LARGE_STEP  = 16'd21;
  localparam logic [15:0] LARGE_LIMIT_X = 16'd218;
  localparam logic [15:0] LARGE_LINE  = 16'd21;
  localparam logic [15:0] LARGE_W     = 16'd24;
  localparam logic [15:0] LARGE_H     = 16'd21;

  localparam logic [5:0] ASCII_BYTES = 6'd16;
  localparam logic [5:0] SMALL_BYTES = 6'd32;
  localparam logic [5:0] LARGE_BYTES = 6'd63;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_ASCII = 2'd0,
    OP_SMALL = 2'd1,
    OP_LARGE = 2'd2,
    OP_PIX   = 2'd3
  } op_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } win_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] idx;    // glyph index or ASCII offset, unscaled
    win_t        win;
    logic [7:0]  bits;   // bitmap byte for pixel commands
  } cmd_t;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        font_mode;
    logic [31:0] ascii_base;
    logic [31:0] small_base;
    logic [31:0] large_base;
  } cfg_t;

endpackage

// ----- rtl/gtr_front.sv -----
// ----------------------------------------------------------------------------
// gtr_front
// Decodes input items: cursor loads, text bytes with GBK lead pairing and
// bitmap bytes. Produces one command per glyph request or bitmap byte.
// ----------------------------------------------------------------------------
module gtr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    in_func,
  input  logic [7:0]    in_data,
  input  logic [15:0]   in_start_x,
  input  logic [15:0]   in_start_y,
  input  gtr_pkg::cfg_t cfg,
  output logic          cmd_push,
  output gtr_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import gtr_pkg::*;

  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        pend_r, pend_nxt;

  logic        accept;
  logic        req;
  op_t         op;
  logic [15:0] zone, pos;
  logic [23:0] gbk_idx;
  logic [15:0] step, limit, line, w, h;
  logic [15:0] col_sum;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  assign zone    = {8'h00, lead_r} - GBK_LEAD_MIN;
  assign pos     = (in_data < GBK_GAP) ? ({8'h00, in_data} - GBK_LOW_OFS)
                                       : ({8'h00, in_data} - GBK_HIGH_OFS);
  assign gbk_idx = 24'(zone) * GBK_ZONE_SPAN + 24'(pos);

  always_comb begin
    req      = 1'b0;
    op       = OP_PIX;
    col_nxt  = col_r;
    row_nxt  = row_r;
    lead_nxt = lead_r;
    pend_nxt = pend_r;
    unique case (in_func)
      FUNC_CURSOR: begin
        col_nxt  = in_start_x;
        row_nxt  = in_start_y;
        pend_nxt = 1'b0;
      end
      FUNC_TEXT: begin
        if (in_data == 8'h00) begin
          pend_nxt = 1'b0;
        end else if (!pend_r) begin
          if (!cfg.font_mode && (in_data < ASCII_LIMIT)) begin
            req = 1'b1;
            op  = OP_ASCII;
          end else begin
            lead_nxt = in_data;
            pend_nxt = 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
          req      = 1'b1;
          op       = cfg.font_mode ? OP_LARGE : OP_SMALL;
        end
      end
      FUNC_BITMAP: begin
        req = 1'b1;
        op  = OP_PIX;
      end
      default: begin
      end
    endcase

    unique case (op)
      OP_ASCII: begin
        step = ASCII_STEP; limit = ASCII_LIMIT_X; line = ASCII_LINE;
        w = ASCII_W; h = ASCII_H;
      end
      OP_SMALL: begin
        step = SMALL_STEP; limit = SMALL_LIMIT_X; line = SMALL_LINE;
        w = SMALL_W; h = SMALL_H;
      end
      OP_LARGE: begin
        step = LARGE_STEP; limit = LARGE_LIMIT_X; line = LARGE_LINE;
        w = LARGE_W; h = LARGE_H;
      end
      default: begin
        step = 16'd0; limit = 16'd0; line = 16'd0;
        w = 16'd0; h = 16'd0;
      end
    endcase

    col_sum = col_r + step;
    // advance the cursor after a glyph request, wrap to a new line
    if (req && (op != OP_PIX)) begin
      if (col_sum > limit) begin
        col_nxt = 16'd0;
        row_nxt = row_r + line;
      end else begin
        col_nxt = col_sum;
      end
    end

    cmd.op         = op;
    cmd.idx        = (op == OP_ASCII) ? ({24'h000000, in_data} - ASCII_FIRST)
                                      : {8'h00, gbk_idx};
    cmd.win.left   = col_r;
    cmd.win.top    = row_r;
    cmd.win.right  = col_r + w - 16'd1;
    cmd.win.bottom = row_r + h - 16'd1;
    cmd.bits       = in_data;
  end

  assign cmd_push = accept && req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 16'd0;
      row_r  <= 16'd0;
      lead_r <= 8'h00;
      pend_r <= 1'b0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      lead_r <= lead_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- rtl/gtr_queue.sv -----
// ----------------------------------------------------------------------------
// gtr_queue
// Short command queue between decode and output: lets each side stall
// on its own.
// ----------------------------------------------------------------------------
module gtr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gtr_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output gtr_pkg::cmd_t rd_data,
  output logic          empty
);
  import gtr_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/gtr_back.sv -----
// ----------------------------------------------------------------------------
// gtr_back
// Executes commands: scales the glyph index and adds the font base for
// requests, expands bitmap bytes MSB first into eight pixels.
// ----------------------------------------------------------------------------
module gtr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gtr_pkg::cfg_t cfg,
  input  gtr_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic          out_kind,
  output logic [31:0]   out_glyph_address,
  output logic [5:0]    out_fetch_bytes,
  output logic [15:0]   out_win_left,
  output logic [15:0]   out_win_top,
  output logic [15:0]   out_win_right,
  output logic [15:0]   out_win_bottom,
  output logic [15:0]   out_pixel_color,
  output logic          out_last
);
  import gtr_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_PIX  = 2'd1,
    B_ADDR = 2'd2
  } bstate_t;

  bstate_t     st_r;
  logic [2:0]  cnt_r;
  logic [7:0]  byte_r;
  logic [31:0] scaled_r;
  op_t         op_r;
  win_t        win_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_addr_r;
  logic [5:0]  out_bytes_r;
  win_t        out_win_r;
  logic [15:0] out_color_r;
  logic        out_last_r;

  logic        out_free, emit, finish, take;
  logic [31:0] scaled_nxt;
  logic [31:0] base;
  logic [5:0]  nbytes;

  assign out_free = !out_valid_r || pop;
  assign emit     = out_free && ((st_r == B_PIX) || (st_r == B_ADDR));
  assign finish   = (st_r == B_IDLE) ||
                    (emit && ((st_r == B_ADDR) || (cnt_r == 3'd7)));
  assign take     = finish && !q_empty;
  assign q_pop    = take;

  always_comb begin
    unique case (q_head.op)
      OP_ASCII: scaled_nxt = {q_head.idx[27:0], 4'b0000};
      OP_SMALL: scaled_nxt = {q_head.idx[26:0], 5'b00000};
      OP_LARGE: scaled_nxt = {q_head.idx[25:0], 6'b000000} - q_head.idx;
      OP_PIX:   scaled_nxt = 32'd0;
    endcase
    unique case (op_r)
      OP_ASCII: begin base = cfg.ascii_base; nbytes = ASCII_BYTES; end
      OP_SMALL: begin base = cfg.small_base; nbytes = SMALL_BYTES; end
      OP_LARGE: begin base = cfg.large_base; nbytes = LARGE_BYTES; end
      OP_PIX:   begin base = 32'd0;          nbytes = 6'd0;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        if (st_r == B_PIX) begin
          out_kind_r  <= KIND_PIX;
          out_addr_r  <= 32'd0;
          out_bytes_r <= 6'd0;
          out_win_r   <= '0;
          out_color_r <= byte_r[7] ? cfg.fg_color : cfg.bg_color;
          out_last_r  <= (cnt_r == 3'd7);
        end else begin
          out_kind_r  <= KIND_REQ;
          out_addr_r  <= scaled_r + base;
          out_bytes_r <= nbytes;
          out_win_r   <= win_r;
          out_color_r <= 16'd0;
          out_last_r  <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end

      // take the next command in the cycle the current one ends
      if (take) begin
        if (q_head.op == OP_PIX) begin
          st_r   <= B_PIX;
          byte_r <= q_head.bits;
          cnt_r  <= 3'd0;
        end else begin
          st_r     <= B_ADDR;
          scaled_r <= scaled_nxt;
          op_r     <= q_head.op;
          win_r    <= q_head.win;
        end
      end else begin
        if (finish) begin
          st_r <= B_IDLE;
        end
        // advance to the next bitmap bit
        if (emit && (st_r == B_PIX)) begin
          byte_r <= {byte_r[6:0], 1'b0};
          cnt_r  <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign empty             = !out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_glyph_address = out_addr_r;
  assign out_fetch_bytes   = out_bytes_r;
  assign out_win_left      = out_win_r.left;
  assign out_win_top       = out_win_r.top;
  assign out_win_right     = out_win_r.right;
  assign out_win_bottom    = out_win_r.bottom;
  assign out_pixel_color   = out_color_r;
  assign out_last          = out_last_r;

  a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_REQ) |-> out_last_r)
    else $error("request result without last");

  a_pix_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (st_r == B_PIX) && (cnt_r == 3'd7) |=> out_last_r && (out_kind_r == KIND_PIX))
    else $error("eighth pixel not marked last");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> finish && !q_empty)
    else $error("command taken while previous one still running");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pop |=> out_valid_r)
    else $error("waiting result dropped");

endmodule

// ----- rtl/glyph_text_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// glyph_text_renderer_unit
// Bitmap font character generator: text bytes to glyph fetch requests,
// fetched bitmap bytes to foreground or background pixels.
// ----------------------------------------------------------------------------
// A request result passes the command queue, the command registers and the
// output register before it is ready; the first pixel of a bitmap byte takes
// the same path. Pixel output runs at one pixel per cycle while pop keeps the
// output register free; each bitmap byte gives eight pixels.
// Reset: synchronous, clears cursor, pending lead byte, queue and output and
// loads the register defaults (foreground 0xFFFF, everything else 0).
module glyph_text_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_glyph_address,
  output logic [5:0]  out_fetch_bytes,
  output logic [15:0] out_win_left,
  output logic [15:0] out_win_top,
  output logic [15:0] out_win_right,
  output logic [15:0] out_win_bottom,
  output logic [15:0] out_pixel_color,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gtr_pkg::*;

  cfg_t cfg_r;
  logic cmd_push, cmd_full, q_pop, q_empty;
  cmd_t cmd, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color   <= 16'hFFFF;
      cfg_r.bg_color   <= 16'h0000;
      cfg_r.font_mode  <= 1'b0;
      cfg_r.ascii_base <= 32'd0;
      cfg_r.small_base <= 32'd0;
      cfg_r.large_base <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FG_COLOR:   cfg_r.fg_color   <= cfg_data[15:0];
        REG_BG_COLOR:   cfg_r.bg_color   <= cfg_data[15:0];
        REG_FONT_MODE:  cfg_r.font_mode  <= cfg_data[0];
        REG_ASCII_BASE: cfg_r.ascii_base <= cfg_data;
        REG_SMALL_BASE: cfg_r.small_base <= cfg_data;
        REG_LARGE_BASE: cfg_r.large_base <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gtr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_func    (in_func),
    .in_data    (in_data),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .cfg        (cfg_r),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .cmd_full   (cmd_full)
  );

  gtr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd),
    .full    (cmd_full),
    .pop     (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  gtr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_glyph_address (out_glyph_address),
    .out_fetch_bytes   (out_fetch_bytes),
    .out_win_left      (out_win_left),
    .out_win_top       (out_win_top),
    .out_win_right     (out_win_right),
    .out_win_bottom    (out_win_bottom),
    .out_pixel_color   (out_pixel_color),
    .out_last          (out_last)
  );

endmodule
